// ===== hdl/tlsib_pkg.sv =====
// ----------------------------------------------------------------------------
// tlsib_pkg
// shared constants, codes and controller/datapath types of the line-scan binner
// ----------------------------------------------------------------------------
package tlsib_pkg;

    localparam int DEF_MAX_COLUMNS       = 256;
    localparam int DEF_MAX_LINES         = 256;
    localparam int DEF_LINE_BUFFER_DEPTH = 64;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int REC_W      = 32;
    localparam int TIME_W     = 48;
    localparam int MT_W       = 12;
    localparam int OVF_W      = 32;
    localparam int FRAME_W    = 17;
    localparam int LINE_W     = 10;

    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PIX_LIM  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_LIM = 3'd5;

    localparam logic [3:0]      CH_ROUTE      = 4'hF;
    localparam logic [MT_W-1:0] RT_OVERFLOW   = 12'd0;
    localparam logic [MT_W-1:0] RT_LINE_START = 12'd1;
    localparam logic [MT_W-1:0] RT_LINE_STOP  = 12'd2;
    localparam logic [MT_W-1:0] RT_FRAME      = 12'd4;

    localparam logic [1:0] ST_PHOTON    = 2'd0;
    localparam logic [1:0] ST_FRAME_END = 2'd1;
    localparam logic [1:0] ST_PIX_OVF   = 2'd2;
    localparam logic [1:0] ST_LINE_OVF  = 2'd3;

    localparam logic [LINE_W-1:0] LINE_SAT = 10'd1023;

    typedef struct packed {
        logic [7:0]      col;
        logic [7:0]      row;
        logic [7:0]      slot;
        logic [MT_W-1:0] mt;
        logic [1:0]      st;
    } t_res;

    typedef struct packed {
        logic accept;
        logic clr_step;
        logic chk;
        logic mul;
        logic div_step;
        logic gen_pix;
        logic gen_ovf;
        logic next_p;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic rec_bin;
        logic clr_done;
        logic in_win;
        logic p_more;
        logic div_done;
        logic pix_hit;
        logic gen_ok;
        logic out_free;
    } t_sts;

endpackage

// ===== hdl/tlsib_if.sv =====
// ----------------------------------------------------------------------------
// tlsib channel interfaces
// record input, result output and register write channels
// ----------------------------------------------------------------------------
interface tlsib_rec_if;
    logic        valid;
    logic        ready;
    logic [31:0] record;
    modport source (output valid, output record, input ready);
    modport sink   (input valid, input record, output ready);
endinterface

interface tlsib_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  pixel_column;
    logic [7:0]  line_row;
    logic [7:0]  pixel_slot;
    logic [11:0] micro_time;
    logic [1:0]  status;
    logic        last_of_run;
    modport source (output valid, output pixel_column, output line_row, output pixel_slot,
                    output micro_time, output status, output last_of_run, input ready);
    modport sink   (input valid, input pixel_column, input line_row, input pixel_slot,
                    input micro_time, input status, input last_of_run, output ready);
endinterface

interface tlsib_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/tttr_line_scan_image_binner_unit.sv =====
// ----------------------------------------------------------------------------
// tttr_line_scan_image_binner_unit
// bins time-tagged photon records of one frame into line/column pixels
// ----------------------------------------------------------------------------
// After reset the pixel count store is cleared one entry per cycle; no
// record is taken until the clear is done, register writes are. A line stop
// with buffered photons walks the line buffer: a photon outside the line
// window takes a read and a window check, a placed photon also a multiply,
// the one-bit-per-cycle column divider and the read-modify-write of the
// pixel count store. Results wait in an output register; a record is taken
// only when that register is free or being read.
module tttr_line_scan_image_binner_unit #(
    parameter int MAX_COLUMNS       = tlsib_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_LINES         = tlsib_pkg::DEF_MAX_LINES,
    parameter int LINE_BUFFER_DEPTH = tlsib_pkg::DEF_LINE_BUFFER_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tlsib_rec_if.sink    i_rec,
    tlsib_res_if.source  o_res,
    tlsib_cfg_if.sink    i_cfg
);
    import tlsib_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_ready;

    assign i_rec.ready = w_ready;

    tlsib_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_rec.valid),
        .o_in_ready (w_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    tlsib_dpath #(
        .MAX_COLUMNS       (MAX_COLUMNS),
        .MAX_LINES         (MAX_LINES),
        .LINE_BUFFER_DEPTH (LINE_BUFFER_DEPTH)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_record (i_rec.record),
        .i_cfg    (i_cfg),
        .o_res    (o_res),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts)
    );

endmodule

// ===== hdl/tlsib_ctrl.sv =====
// ----------------------------------------------------------------------------
// tlsib_ctrl
// sequencer: store clear, record intake and per-photon line binning steps
// ----------------------------------------------------------------------------
module tlsib_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  tlsib_pkg::t_sts i_sts,
    output tlsib_pkg::t_cmd o_cmd
);
    import tlsib_pkg::*;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_CHK   = 4'd3;
    localparam logic [3:0] S_MUL   = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_PRD   = 4'd6;
    localparam logic [3:0] S_PWR   = 4'd7;
    localparam logic [3:0] S_OVF   = 4'd8;
    localparam logic [3:0] S_FLUSH = 4'd9;

    logic [3:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready   = i_sts.out_free;
                o_cmd.accept = i_in_valid && i_sts.out_free;
                if (o_cmd.accept && i_sts.rec_bin) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                o_cmd.chk = 1'b1;
                if (i_sts.in_win) begin
                    n_state = S_MUL;
                end else begin
                    o_cmd.next_p = 1'b1;
                    n_state      = i_sts.p_more ? S_RD : S_FLUSH;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = S_PRD;
                end
            end
            S_PRD: begin
                n_state = S_PWR;
            end
            S_PWR: begin
                if (i_sts.gen_ok) begin
                    o_cmd.gen_pix = 1'b1;
                    if (i_sts.pix_hit) begin
                        n_state = S_OVF;
                    end else begin
                        o_cmd.next_p = 1'b1;
                        n_state      = i_sts.p_more ? S_RD : S_FLUSH;
                    end
                end
            end
            S_OVF: begin
                if (i_sts.gen_ok) begin
                    o_cmd.gen_ovf = 1'b1;
                    n_state       = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (i_sts.gen_ok) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

// ===== hdl/tlsib_dpath.sv =====
// ----------------------------------------------------------------------------
// tlsib_dpath
// registers, record decode, line buffer, serial divider, pixel count store
// ----------------------------------------------------------------------------
module tlsib_dpath #(
    parameter int MAX_COLUMNS       = tlsib_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_LINES         = tlsib_pkg::DEF_MAX_LINES,
    parameter int LINE_BUFFER_DEPTH = tlsib_pkg::DEF_LINE_BUFFER_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [tlsib_pkg::REC_W-1:0]  i_record,
    tlsib_cfg_if.sink                    i_cfg,
    tlsib_res_if.source                  o_res,
    input  tlsib_pkg::t_cmd              i_cmd,
    output tlsib_pkg::t_sts              o_sts
);
    import tlsib_pkg::*;

    localparam int STORE = MAX_COLUMNS * MAX_LINES;
    localparam int AW    = (STORE > 1) ? $clog2(STORE) : 1;
    localparam int BW    = (LINE_BUFFER_DEPTH > 1) ? $clog2(LINE_BUFFER_DEPTH) : 1;
    localparam int FW    = $clog2(LINE_BUFFER_DEPTH + 1);
    localparam int QB    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int DCW   = (QB > 1) ? $clog2(QB) : 1;
    localparam int NW    = TIME_W + 9;
    localparam int DSW   = TIME_W + QB;
    localparam int CW    = (NW > DSW) ? NW : DSW;

    // registers
    logic [3:0]  r_ch;
    logic [15:0] r_fsel;
    logic [8:0]  r_lw, r_fh;
    logic [7:0]  r_pl;
    logic [6:0]  r_ll;

    // tracking state
    logic [FRAME_W-1:0] r_frames;
    logic [LINE_W-1:0]  r_lines;
    logic [OVF_W-1:0]   r_ovf;
    logic [TIME_W-1:0]  r_start, r_stop, r_den;
    logic               r_sv;
    logic [FW-1:0]      r_fill;
    logic               r_halted;

    // binning
    logic [FW-1:0]      r_p;
    logic [AW-1:0]      r_base;
    logic [7:0]         r_row;
    logic [TIME_W-1:0]  r_bq_t, r_diff;
    logic [MT_W-1:0]    r_bq_mt;
    logic [NW-1:0]      r_num;
    logic [DSW-1:0]     r_dsh;
    logic [QB-1:0]      r_q;
    logic [DCW-1:0]     r_dcnt;
    logic [7:0]         r_pix_q;
    logic [AW-1:0]      r_clr;

    // results
    t_res r_hold, r_out;
    logic r_hv, r_ov, r_olast;

    logic [MT_W-1:0]   buf_mt [LINE_BUFFER_DEPTH];
    logic [TIME_W-1:0] buf_t  [LINE_BUFFER_DEPTH];
    logic [7:0]        pmem   [STORE];

    logic [3:0]         ch;
    logic [MT_W-1:0]    mt;
    logic [TIME_W-1:0]  rtime;
    logic [FRAME_W-1:0] target;
    logic               in_frame, pre_frame, is_route, usable, rec_bin;
    logic [8:0]         w, h;
    logic [LINE_W-1:0]  ln;
    logic [18:0]        base_full;
    logic [6:0]         lim, fill_next7;
    logic [FW-1:0]      fill_next;
    logic               buf_wr;
    logic               out_free, gen_ok, ge;
    logic [AW-1:0]      paddr, waddr;
    logic               pwe;
    logic [7:0]         pwdata, pix_inc;
    t_res               res_pix, res_ovf, res_now;
    logic               load_now;

    assign ch    = i_record[31:28];
    assign mt    = i_record[27:16];
    assign rtime = {r_ovf, i_record[15:0]};

    assign target    = FRAME_W'(r_fsel) + FRAME_W'(1);
    assign in_frame  = (r_frames == target);
    assign pre_frame = (r_frames < target);
    assign is_route  = (ch == CH_ROUTE);

    assign w  = (int'(r_lw) > MAX_COLUMNS) ? 9'(MAX_COLUMNS) : r_lw;
    assign h  = (int'(r_fh) > MAX_LINES) ? 9'(MAX_LINES) : r_fh;
    assign ln = r_lines - LINE_W'(1);
    assign base_full = ln * w;

    assign usable  = r_sv && (r_lines != '0) && (ln < {1'b0, h}) && (w != '0);
    assign rec_bin = !r_halted && in_frame && is_route && (mt == RT_LINE_STOP)
                     && usable && (r_fill != '0);

    assign lim = ((r_ll == '0) || (int'(r_ll) > LINE_BUFFER_DEPTH))
                 ? 7'(LINE_BUFFER_DEPTH) : r_ll;
    assign buf_wr     = (int'(r_fill) < LINE_BUFFER_DEPTH);
    assign fill_next  = buf_wr ? r_fill + FW'(1) : r_fill;
    assign fill_next7 = 7'(fill_next);

    assign out_free = !r_ov || o_res.ready;
    assign gen_ok   = !r_hv || out_free;

    assign ge = CW'(r_num) >= CW'(r_dsh);

    assign paddr   = r_base + AW'(r_q);
    assign pix_inc = r_pix_q + 8'd1;
    assign pwe     = i_cmd.clr_step || i_cmd.gen_pix;
    assign waddr   = i_cmd.clr_step ? r_clr : paddr;
    assign pwdata  = i_cmd.clr_step ? 8'd0 : pix_inc;

    assign res_pix = '{col: 8'(r_q), row: r_row, slot: r_pix_q, mt: r_bq_mt, st: ST_PHOTON};
    assign res_ovf = '{col: 8'd0, row: 8'd0, slot: 8'd0, mt: '0, st: ST_PIX_OVF};

    assign o_sts.rec_bin  = rec_bin;
    assign o_sts.clr_done = (r_clr == AW'(STORE - 1));
    assign o_sts.in_win   = (r_bq_t >= r_start) && (r_bq_t < r_stop);
    assign o_sts.p_more   = ({1'b0, r_p} + (FW+1)'(1)) < {1'b0, r_fill};
    assign o_sts.div_done = (r_dcnt == DCW'(QB - 1));
    assign o_sts.pix_hit  = (pix_inc == r_pl);
    assign o_sts.gen_ok   = gen_ok;
    assign o_sts.out_free = out_free;

    assign i_cfg.ready        = 1'b1;
    assign o_res.valid        = r_ov;
    assign o_res.pixel_column = r_out.col;
    assign o_res.line_row     = r_out.row;
    assign o_res.pixel_slot   = r_out.slot;
    assign o_res.micro_time   = r_out.mt;
    assign o_res.status       = r_out.st;
    assign o_res.last_of_run  = r_olast;

    // single-result records at intake
    always_comb begin
        load_now = 1'b0;
        res_now  = '{col: 8'd0, row: 8'd0, slot: 8'd0, mt: '0, st: ST_FRAME_END};
        if (i_cmd.accept && !r_halted && in_frame) begin
            if (is_route) begin
                load_now = (mt == RT_FRAME);
            end else if (ch == r_ch) begin
                load_now   = (fill_next7 >= lim);
                res_now.st = ST_LINE_OVF;
            end
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && !r_halted && in_frame && !is_route && ch == r_ch && buf_wr) begin
            buf_mt[r_fill[BW-1:0]] <= mt;
            buf_t[r_fill[BW-1:0]]  <= rtime;
        end
        r_bq_mt <= buf_mt[r_p[BW-1:0]];
        r_bq_t  <= buf_t[r_p[BW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (pwe) begin
            pmem[waddr] <= pwdata;
        end
        r_pix_q <= pmem[paddr];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && is_route && mt == RT_LINE_STOP) begin
            r_stop <= rtime;
            r_den  <= rtime - r_start;
            r_base <= AW'(base_full);
            r_row  <= ln[7:0];
        end
        if (i_cmd.chk) begin
            r_diff <= r_bq_t - r_start;
        end
        if (i_cmd.mul) begin
            r_num  <= NW'(w * r_diff);
            r_dsh  <= DSW'(r_den) << (QB - 1);
            r_q    <= '0;
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            if (ge) begin
                r_num <= NW'(CW'(r_num) - CW'(r_dsh));
            end
            r_dsh  <= r_dsh >> 1;
            r_q    <= QB'({r_q, ge});
            r_dcnt <= r_dcnt + DCW'(1);
        end
        if (i_cmd.gen_pix) begin
            r_hold <= res_pix;
        end else if (i_cmd.gen_ovf) begin
            r_hold <= res_ovf;
        end
        if (load_now) begin
            r_out   <= res_now;
            r_olast <= 1'b1;
        end else if ((i_cmd.gen_pix || i_cmd.gen_ovf) && r_hv) begin
            r_out   <= r_hold;
            r_olast <= 1'b0;
        end else if (i_cmd.flush && r_hv) begin
            r_out   <= r_hold;
            r_olast <= 1'b1;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch     <= 4'd0;
            r_fsel   <= 16'd0;
            r_lw     <= 9'd256;
            r_fh     <= 9'd256;
            r_pl     <= 8'd255;
            r_ll     <= 7'd64;
            r_frames <= '0;
            r_lines  <= '0;
            r_ovf    <= '0;
            r_start  <= '0;
            r_sv     <= 1'b0;
            r_fill   <= '0;
            r_halted <= 1'b0;
            r_p      <= '0;
            r_clr    <= '0;
            r_hv     <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_CHANNEL:  r_ch   <= i_cfg.data[3:0];
                    REG_FRAME:    r_fsel <= i_cfg.data;
                    REG_WIDTH:    r_lw   <= i_cfg.data[8:0];
                    REG_HEIGHT:   r_fh   <= i_cfg.data[8:0];
                    REG_PIX_LIM:  r_pl   <= i_cfg.data[7:0];
                    REG_LINE_LIM: r_ll   <= i_cfg.data[6:0];
                    default: ;
                endcase
            end

            if (i_cmd.clr_step) begin
                r_clr <= r_clr + AW'(1);
            end

            if (i_cmd.accept && !r_halted) begin
                if (in_frame) begin
                    if (is_route) begin
                        case (mt)
                            RT_OVERFLOW: begin
                                r_ovf <= r_ovf + OVF_W'(1);
                            end
                            RT_LINE_START: begin
                                r_start <= rtime;
                                r_sv    <= 1'b1;
                                if (r_lines < LINE_SAT) begin
                                    r_lines <= r_lines + LINE_W'(1);
                                end
                            end
                            RT_LINE_STOP: begin
                                r_p <= '0;
                                if (!rec_bin) begin
                                    r_fill <= '0;
                                    r_ovf  <= '0;
                                    r_sv   <= 1'b0;
                                end
                            end
                            RT_FRAME: begin
                                r_frames <= r_frames + FRAME_W'(1);
                                r_halted <= 1'b1;
                            end
                            default: ;
                        endcase
                    end else if (ch == r_ch) begin
                        r_fill <= fill_next;
                        if (fill_next7 >= lim) begin
                            r_halted <= 1'b1;
                        end
                    end
                end else if (pre_frame && is_route && mt == RT_FRAME) begin
                    r_frames <= r_frames + FRAME_W'(1);
                end
            end

            if (i_cmd.next_p) begin
                r_p <= r_p + FW'(1);
            end
            if (i_cmd.gen_ovf) begin
                r_halted <= 1'b1;
            end
            if (i_cmd.flush) begin
                r_fill <= '0;
                r_ovf  <= '0;
                r_sv   <= 1'b0;
            end

            if (i_cmd.gen_pix || i_cmd.gen_ovf) begin
                r_hv <= 1'b1;
            end else if (i_cmd.flush) begin
                r_hv <= 1'b0;
            end

            if (load_now || ((i_cmd.gen_pix || i_cmd.gen_ovf || i_cmd.flush) && r_hv)) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

endmodule

// ===== dv/tttr_line_scan_image_binner_unit_tb.sv =====
// ----------------------------------------------------------------------------
// tttr_line_scan_image_binner_unit_tb
// Drives time-tagged records and register writes into the line-scan binner
// and checks every result beat against a behavioral model of the block. A
// short directed table opens the run. Random phases follow, each with its own
// register setting, frame markers and scan lines. The last phase uses small
// limits and ends in a halt. Both the sender and the receiver idle at random.
// ----------------------------------------------------------------------------
module tttr_line_scan_image_binner_unit_tb;
    import tlsib_pkg::*;

    localparam int STORE_SIZE = DEF_MAX_COLUMNS * DEF_MAX_LINES;
    localparam int DOG_LIMIT  = 200000;
    localparam int WALK_SLACK = 300;

    typedef struct packed {
        t_res res;
        logic last;
    } t_placement;

    typedef struct {
        logic [31:0] rec;
        logic        typed;
        t_placement  want;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    tlsib_rec_if rec_if ();
    tlsib_res_if res_if ();
    tlsib_cfg_if cfg_if ();

    tttr_line_scan_image_binner_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rec   (rec_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    // model registers
    logic [3:0]  sel_ch;
    logic [15:0] sel_frame;
    logic [8:0]  line_w;
    logic [8:0]  frame_h;
    logic [7:0]  pix_lim;
    logic [6:0]  line_lim;

    // model state
    int unsigned frame_cnt;
    int unsigned lines_cnt;
    logic [31:0] ovf_cnt;
    logic [63:0] start_t;
    logic        start_ok;
    logic [11:0] buf_mt [DEF_LINE_BUFFER_DEPTH];
    logic [63:0] buf_t  [DEF_LINE_BUFFER_DEPTH];
    int unsigned fill;
    logic [7:0]  pix_cnt [STORE_SIZE];
    logic        halted;

    t_placement placements_q[$];

    int  errs = 0, recs_sent = 0, res_seen = 0, cfg_sent = 0, dog = 0;
    logic calm = 1'b0;
    int  stall_lvl = 0, stall_tmr = 0, burst_left = 4;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    task automatic push_result(input logic [7:0] col, input logic [7:0] row,
                               input logic [7:0] slot, input logic [11:0] mt,
                               input logic [1:0] st);
        t_placement p;
        p.res.col  = col;
        p.res.row  = row;
        p.res.slot = slot;
        p.res.mt   = mt;
        p.res.st   = st;
        p.last     = 1'b0;
        placements_q.push_back(p);
    endtask

    task automatic bin_photons(input logic [63:0] stop_t, inout int n);
        int unsigned w, h, ln, idx, p;
        logic [63:0] t, pix;
        logic [7:0]  slot;
        logic        usable;
        w = (line_w > DEF_MAX_COLUMNS) ? DEF_MAX_COLUMNS : line_w;
        h = (frame_h > DEF_MAX_LINES) ? DEF_MAX_LINES : frame_h;
        ln = lines_cnt - 1;
        usable = start_ok && lines_cnt > 0 && ln < h && w > 0;
        for (p = 0; usable && p < fill && p < DEF_LINE_BUFFER_DEPTH; p++) begin
            t = buf_t[p];
            if (t < start_t || t >= stop_t)
                continue;
            pix = (64'(w) * (t - start_t)) / (stop_t - start_t);
            if (pix >= w)
                pix = w - 1;
            idx = (ln * w + 32'(pix)) % STORE_SIZE;
            slot = pix_cnt[idx];
            pix_cnt[idx] = slot + 8'd1;
            push_result(pix[7:0], ln[7:0], slot, buf_mt[p], ST_PHOTON);
            n++;
            if (pix_cnt[idx] == pix_lim) begin
                push_result('0, '0, '0, '0, ST_PIX_OVF);
                n++;
                halted = 1'b1;
                return;
            end
        end
        fill = 0;
        ovf_cnt = '0;
        start_ok = 1'b0;
    endtask

    task automatic take_record(input logic [31:0] r);
        logic [3:0]  ch;
        logic [11:0] mt;
        logic [63:0] rt;
        int unsigned tgt, lim;
        int n;
        ch = r[31:28];
        mt = r[27:16];
        rt = 64'(r[15:0]) + (64'(ovf_cnt) << 16);
        tgt = sel_frame + 1;
        n = 0;
        if (halted)
            return;
        if (frame_cnt == tgt) begin
            if (ch == CH_ROUTE) begin
                case (mt)
                    RT_OVERFLOW: ovf_cnt++;
                    RT_LINE_START: begin
                        start_t = rt;
                        start_ok = 1'b1;
                        if (lines_cnt < LINE_SAT)
                            lines_cnt++;
                    end
                    RT_LINE_STOP: bin_photons(rt, n);
                    RT_FRAME: begin
                        frame_cnt++;
                        halted = 1'b1;
                        push_result('0, '0, '0, '0, ST_FRAME_END);
                        n++;
                    end
                    default: ;
                endcase
            end else if (ch == sel_ch) begin
                lim = line_lim;
                if (lim == 0 || lim > DEF_LINE_BUFFER_DEPTH)
                    lim = DEF_LINE_BUFFER_DEPTH;
                if (fill < DEF_LINE_BUFFER_DEPTH) begin
                    buf_mt[fill] = mt;
                    buf_t[fill] = rt;
                    fill++;
                end
                if (fill >= lim) begin
                    halted = 1'b1;
                    push_result('0, '0, '0, '0, ST_LINE_OVF);
                    n++;
                end
            end
        end else if (frame_cnt < tgt) begin
            if (ch == CH_ROUTE && mt == RT_FRAME)
                frame_cnt++;
        end
        if (n > 0)
            placements_q[placements_q.size()-1].last = 1'b1;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_sent++;
        case (idx)
            REG_CHANNEL:  sel_ch = val[3:0];
            REG_FRAME:    sel_frame = val;
            REG_WIDTH:    line_w = val[8:0];
            REG_HEIGHT:   frame_h = val[8:0];
            REG_PIX_LIM:  pix_lim = val[7:0];
            REG_LINE_LIM: line_lim = val[6:0];
            default: ;
        endcase
    endtask

    task automatic send_rec(input logic [31:0] r);
        rec_if.valid  <= 1'b1;
        rec_if.record <= r;
        do @(posedge i_clk); while (!rec_if.ready);
        recs_sent++;
        take_record(r);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            if (!calm) begin
                rec_if.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    endtask

    task automatic settle();
        rec_if.valid <= 1'b0;
        while (placements_q.size() > 0)
            @(posedge i_clk);
        repeat (WALK_SLACK) @(posedge i_clk);
    endtask

    function automatic logic [31:0] route(input logic [11:0] code, input logic [15:0] s);
        return {CH_ROUTE, code, s};
    endfunction

    function automatic logic [31:0] noise();
        logic [31:0] r;
        r = $urandom;
        if (r[31:28] == CH_ROUTE && r[27:16] == RT_FRAME)
            r[27:16] = 12'd5;
        return r;
    endfunction

    task automatic scan_line();
        logic [15:0] s;
        logic [3:0]  other;
        int np, k;
        s = $urandom_range(0, 16'hF000);
        send_rec(route(RT_LINE_START, s));
        np = $urandom_range(0, 8);
        repeat (np) begin
            k = $urandom_range(0, 9);
            other = 4'($urandom_range(0, 14));
            if (other == sel_ch)
                other = 4'((other + 1) % 15);
            if (k == 0)
                send_rec(route(RT_OVERFLOW, 16'($urandom)));
            else if (k == 1)
                send_rec({other, 12'($urandom), 16'($urandom)});
            else if (k == 2)
                send_rec({sel_ch, 12'($urandom), 16'($urandom_range(0, s))});
            else if (k == 3)
                send_rec(noise());
            else
                send_rec({sel_ch, 12'($urandom), 16'($urandom_range(s, 16'hFFFF))});
        end
        if ($urandom_range(0, 2) == 0)
            send_rec(route(RT_OVERFLOW, 16'($urandom)));
        if ($urandom_range(0, 3) == 0)
            send_rec(route(RT_LINE_STOP, 16'($urandom)));
        else
            send_rec(route(RT_LINE_STOP, 16'($urandom_range(s, 16'hFFFF))));
    endtask

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (stall_tmr == 0) begin
            stall_lvl <= $urandom_range(0, 7);
            stall_tmr <= $urandom_range(10, 80);
        end else begin
            stall_tmr <= stall_tmr - 1;
        end
        res_if.ready <= calm || ($urandom_range(0, 7) >= stall_lvl);
    end

    // result checker
    always @(posedge i_clk) begin
        t_placement want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            res_seen++;
            if (placements_q.size() == 0) begin
                $display("%0t: unexpected result beat col %0d row %0d st %0d", $time,
                         res_if.pixel_column, res_if.line_row, res_if.status);
                errs++;
            end else begin
                want = placements_q.pop_front();
                if (res_if.pixel_column !== want.res.col || res_if.line_row !== want.res.row ||
                    res_if.pixel_slot !== want.res.slot || res_if.micro_time !== want.res.mt ||
                    res_if.status !== want.res.st || res_if.last_of_run !== want.last) begin
                    $display("%0t: mismatch expected col %0d row %0d slot %0d mt %0h st %0d last %0b",
                             $time, want.res.col, want.res.row, want.res.slot, want.res.mt,
                             want.res.st, want.last);
                    $display("%0t:          actual   col %0d row %0d slot %0d mt %0h st %0d last %0b",
                             $time, res_if.pixel_column, res_if.line_row, res_if.pixel_slot,
                             res_if.micro_time, res_if.status, res_if.last_of_run);
                    errs++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((rec_if.valid && rec_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            dog <= 0;
        end else if (dog >= DOG_LIMIT) begin
            $display("timeout with %0d results outstanding", placements_q.size());
            $display("simulation failed");
            $finish;
        end else begin
            dog <= dog + 1;
        end
    end

    initial begin
        t_row rows[18];
        int n0, ph, nl;
        logic [15:0] fsel;

        sel_ch = '0; sel_frame = '0; line_w = 9'd256; frame_h = 9'd256;
        pix_lim = 8'd255; line_lim = 7'd64;
        frame_cnt = 0; lines_cnt = 0; ovf_cnt = '0; start_t = '0; start_ok = 1'b0;
        fill = 0; halted = 1'b0;
        foreach (pix_cnt[i]) pix_cnt[i] = '0;

        i_rst_n       <= 1'b0;
        rec_if.valid  <= 1'b0;
        rec_if.record <= '0;
        cfg_if.valid  <= 1'b0;
        cfg_if.index  <= '0;
        cfg_if.data   <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table at reset settings
        foreach (rows[i]) begin
            rows[i].typed = 1'b0;
            rows[i].want  = '0;
        end
        rows[0].rec  = {4'd0, 12'h123, 16'h0050};
        rows[1].rec  = route(RT_OVERFLOW, 16'h0000);
        rows[2].rec  = route(RT_FRAME, 16'h0001);
        rows[3].rec  = route(RT_LINE_START, 16'd100);
        rows[4].rec  = {4'd0, 12'hABC, 16'd100};
        rows[5].rec  = {4'd1, 12'h555, 16'd150};
        rows[6].rec  = {4'd0, 12'h000, 16'd99};
        rows[7].rec  = route(12'd3, 16'd200);
        rows[8].rec  = route(RT_LINE_STOP, 16'd356);
        rows[8].typed = 1'b1;
        rows[8].want = '{res: '{col: 8'd0, row: 8'd0, slot: 8'd0, mt: 12'hABC,
                                st: ST_PHOTON}, last: 1'b1};
        rows[9].rec  = route(RT_LINE_STOP, 16'd400);
        rows[10].rec = route(RT_LINE_START, 16'hFFF0);
        rows[11].rec = route(RT_OVERFLOW, 16'hFFFF);
        rows[12].rec = {4'd0, 12'hFFF, 16'h0000};
        rows[13].rec = {4'd0, 12'h7FF, 16'hFFFF};
        rows[14].rec = {4'hE, 12'hFFF, 16'hFFFF};
        rows[15].rec = route(12'hFFF, 16'hFFFF);
        rows[16].rec = route(RT_OVERFLOW, 16'h8000);
        rows[17].rec = route(RT_LINE_STOP, 16'h0000);
        foreach (rows[i]) begin
            n0 = placements_q.size();
            send_rec(rows[i].rec);
            if (rows[i].typed) begin
                while (placements_q.size() > n0)
                    void'(placements_q.pop_back());
                placements_q.push_back(rows[i].want);
            end
        end

        // random phases, each with its own register setting
        ph = 0;
        while (recs_sent < 225) begin
            settle();
            calm = (ph % 3 == 1);
            case (ph % 5)
                0: write_reg(REG_CHANNEL, 16'd14);
                1: write_reg(REG_CHANNEL, 16'd0);
                default: write_reg(REG_CHANNEL, 16'($urandom_range(0, 14)));
            endcase
            case (ph % 5)
                0: write_reg(REG_WIDTH, 16'd1);
                1: write_reg(REG_WIDTH, 16'd511);
                2: write_reg(REG_WIDTH, 16'd0);
                3: write_reg(REG_WIDTH, 16'd256);
                default: write_reg(REG_WIDTH, 16'($urandom_range(2, 255)));
            endcase
            case (ph % 4)
                0: write_reg(REG_HEIGHT, 16'd256);
                1: write_reg(REG_HEIGHT, 16'd511);
                2: write_reg(REG_HEIGHT, 16'($urandom_range(0, 1)));
                default: write_reg(REG_HEIGHT, 16'($urandom_range(2, 255)));
            endcase
            case (ph % 3)
                0: write_reg(REG_PIX_LIM, 16'd0);
                1: write_reg(REG_PIX_LIM, 16'd255);
                default: write_reg(REG_PIX_LIM, 16'($urandom_range(200, 254)));
            endcase
            case (ph % 4)
                0: write_reg(REG_LINE_LIM, 16'd64);
                1: write_reg(REG_LINE_LIM, 16'd0);
                2: write_reg(REG_LINE_LIM, 16'd127);
                default: write_reg(REG_LINE_LIM, 16'($urandom_range(12, 63)));
            endcase
            if (ph == 2) begin
                // frame far ahead: everything is skipped
                write_reg(REG_FRAME, 16'hFFFF);
                cfg_if.valid <= 1'b0;
                repeat (6) send_rec(noise());
                send_rec(route(RT_FRAME, 16'($urandom)));
                scan_line();
            end else begin
                fsel = 16'(frame_cnt - 1 + $urandom_range(0, 2));
                write_reg(REG_FRAME, fsel);
                cfg_if.valid <= 1'b0;
                while (frame_cnt < sel_frame + 1)
                    send_rec(route(RT_FRAME, 16'($urandom)));
                nl = $urandom_range(3, 6);
                repeat (nl) begin
                    scan_line();
                    if ($urandom_range(0, 2) == 0)
                        send_rec(noise());
                end
            end
            ph++;
        end

        // last phase: small limits, then a frame marker
        settle();
        calm = 1'b0;
        write_reg(REG_FRAME, 16'(frame_cnt - 1));
        write_reg(REG_WIDTH, 16'($urandom_range(1, 4)));
        write_reg(REG_HEIGHT, 16'd256);
        write_reg(REG_PIX_LIM, 16'($urandom_range(1, 4)));
        write_reg(REG_LINE_LIM, 16'($urandom_range(2, 9)));
        cfg_if.valid <= 1'b0;
        repeat (4) scan_line();
        send_rec(route(RT_FRAME, 16'($urandom)));
        repeat (3) send_rec(noise());

        settle();
        $display("%0d records over %0d phases, %0d register writes", recs_sent, ph + 1,
                 cfg_sent);
        $display("%0d result beats checked, halted %0b, %0d errors", res_seen, halted, errs);
        if (errs == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
